>>> hw/rtl/gkg_pkg.sv
// shared types, register codes and saturation helper for the gated key gram block
package gkg_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 1'b1;

    localparam logic [6:0] CHUNK_LEN_RST = 7'd64;
    localparam logic [7:0] KEY_LEN_RST   = 8'd64;

    localparam int JOB_ROW_W = 7;
    localparam int JOB_LEN_W = 8;

    typedef struct packed {
        logic signed [15:0] key_elem;
        logic signed [23:0] gate;
        logic signed [15:0] beta_val;
        logic               seq_end;
    } in_word_t;

    typedef struct packed {
        logic        [5:0]  row_index;
        logic        [5:0]  col_index;
        logic signed [31:0] a_value;
        logic signed [31:0] gate_cumsum;
        logic               row_last;
    } out_word_t;

    typedef struct packed {
        logic        [JOB_ROW_W-1:0] row;
        logic        [JOB_LEN_W-1:0] len;
        logic signed [31:0]          cs;
        logic signed [15:0]          beta;
        logic                        bank;
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/gkg_ram.sv
// generic single write port ram with one registered read port
module gkg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/gkg_exp.sv
// iterative exp unit for non-positive gate differences, q1.16 result
module gkg_exp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] d,
    output logic               done,
    output logic [16:0]        e
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_T2   = 3'd2;
    localparam logic [2:0] S_Y    = 3'd3;
    localparam logic [2:0] S_T3   = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_SQ   = 3'd6;
    localparam logic [2:0] S_RND  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         sq_reg, sq_next;
    logic               done_reg, done_next;
    logic signed [32:0] d_reg, d_next;
    logic [25:0]        r_reg, r_next;
    logic [20:0]        t2_reg, t2_next;
    logic [16:0]        y_reg, y_next;
    logic [16:0]        t3_reg, t3_next;
    logic [30:0]        sum_reg, sum_next;
    logic [30:0]        t_reg, t_next;
    logic [16:0]        e_reg, e_next;

    logic [32:0] m;
    logic [51:0] p_rr;
    logic [46:0] p_t2r;
    logic [33:0] p_y;
    logic [42:0] p_t3r;
    logic [61:0] p_sq;
    logic [31:0] acc;

    always_comb
    begin
        m     = 33'(-d_reg);
        p_rr  = r_reg * r_reg;
        p_t2r = 47'(t2_reg) * 47'(r_reg);
        p_y   = y_reg * 17'd43691;
        p_t3r = 43'(t3_reg) * 43'(r_reg);
        p_sq  = t_reg * t_reg;
        acc   = 32'(sum_reg) + 32'(t2_reg) - 32'(t3_reg) + 32'(p_t3r >> 32);

        state_next = state_reg;
        sq_next    = sq_reg;
        done_next  = 1'b0;
        d_next     = d_reg;
        r_next     = r_reg;
        t2_next    = t2_reg;
        y_next     = y_reg;
        t3_next    = t3_reg;
        sum_next   = sum_reg;
        t_next     = t_reg;
        e_next     = e_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    d_next     = d;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if ((!d_reg[32] && (d_reg != '0)) || (m >= 33'd786432))
                begin
                    e_next     = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    r_next     = {m[19:0], 6'b0};
                    state_next = S_T2;
                end
            end
            S_T2:
            begin
                t2_next    = 21'(p_rr >> 31);
                sum_next   = 31'(32'd1073741824 - 32'(r_reg));
                state_next = S_Y;
            end
            S_Y:
            begin
                y_next     = 17'(p_t2r >> 30);
                state_next = S_T3;
            end
            S_T3:
            begin
                t3_next    = 17'(p_y >> 17);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                t_next     = acc[30:0];
                sq_next    = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                t_next  = 31'((p_sq + 62'd536870912) >> 30);
                sq_next = sq_reg + 3'd1;
                if (sq_reg == 3'd7)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                e_next     = 17'((32'(t_reg) + 32'd8192) >> 14);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sq_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sq_reg    <= sq_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        r_reg   <= r_next;
        t2_reg  <= t2_next;
        y_reg   <= y_next;
        t3_reg  <= t3_next;
        sum_reg <= sum_next;
        t_reg   <= t_next;
        e_reg   <= e_next;
    end

    assign done = done_reg;
    assign e    = e_reg;

endmodule

>>> hw/rtl/gkg_front.sv
// front end: takes key words, stores keys, accumulates dot products, issues row jobs
module gkg_front #(
    parameter int MAX_CHUNK = 64,
    parameter int MAX_KEY   = 128,
    localparam int CW  = $clog2(MAX_CHUNK + 1),
    localparam int IW  = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1,
    localparam int KCW = $clog2(MAX_KEY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  gkg_pkg::in_word_t   item,
    input  logic [CW-1:0]       ch_len,
    input  logic [KCW-1:0]      key_len,
    input  logic                back_idle,
    output logic                job_valid,
    output gkg_pkg::job_t       job,
    output logic                dots_bank,
    output logic                dots_we,
    output logic [IW-1:0]       dots_waddr,
    output logic signed [39:0]  dots_wdata,
    output logic [IW-1:0]       dots_raddr,
    input  logic signed [39:0]  dots_rdata,
    output logic                cs_we,
    output logic [IW-1:0]       cs_waddr,
    output logic signed [31:0]  cs_wdata
);

    localparam int KIW    = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int KDEPTH = MAX_CHUNK * MAX_KEY;
    localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      tok_reg, tok_next;
    logic [KCW-1:0]     elem_reg, elem_next;
    logic [CW-1:0]      jc_reg, jc_next;
    logic signed [31:0] run_reg, run_next;
    logic               bank_reg, bank_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic [IW-1:0]      j1_reg, j2_reg;
    logic signed [15:0] ke_reg, ke_next;
    logic signed [23:0] gate_reg, gate_next;
    logic signed [15:0] beta_reg, beta_next;
    logic               send_reg, send_next;
    logic               last_reg, last_next;
    logic               first_reg, first_next;
    logic signed [31:0] prod2_reg;
    logic signed [39:0] dot2_reg;

    logic               accept;
    logic               fin_go;
    logic signed [31:0] sum_new;
    logic [KAW-1:0]     key_waddr, key_raddr;
    logic [15:0]        key_rdata;
    logic [CW-1:0]      tok_inc;

    assign accept  = (state_reg == ST_IDLE) && push;
    assign fin_go  = (state_reg == ST_FIN) && back_idle;
    assign sum_new = gkg_pkg::sat32(64'(run_reg) + 64'(gate_reg));
    assign tok_inc = tok_reg + CW'(1);

    assign key_waddr = KAW'(KAW'(tok_reg[IW-1:0]) * KAW'(MAX_KEY)) + KAW'(elem_reg[KIW-1:0]);
    assign key_raddr = KAW'(KAW'(jc_reg[IW-1:0]) * KAW'(MAX_KEY)) + KAW'(elem_reg[KIW-1:0]);

    gkg_ram #(.WIDTH(16), .DEPTH(KDEPTH)) u_key_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (key_waddr),
        .wdata (item.key_elem),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        tok_next   = tok_reg;
        elem_next  = elem_reg;
        jc_next    = jc_reg;
        run_next   = run_reg;
        bank_next  = bank_reg;
        ke_next    = ke_reg;
        gate_next  = gate_reg;
        beta_next  = beta_reg;
        send_next  = send_reg;
        last_next  = last_reg;
        first_next = first_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    ke_next    = item.key_elem;
                    gate_next  = item.gate;
                    beta_next  = item.beta_val;
                    send_next  = item.seq_end;
                    first_next = (elem_reg == '0);
                    last_next  = ((elem_reg + KCW'(1)) >= key_len);
                    jc_next    = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (jc_reg < tok_reg)
                begin
                    jc_next = jc_reg + CW'(1);
                end
                else if (!v1_reg && !v2_reg)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        elem_next  = elem_reg + KCW'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN:
            begin
                if (back_idle)
                begin
                    elem_next = '0;
                    bank_next = !bank_reg;
                    if (send_reg || (tok_inc >= ch_len))
                    begin
                        tok_next = '0;
                        run_next = '0;
                    end
                    else
                    begin
                        tok_next = tok_inc;
                        run_next = sum_new;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign v1_next = (state_reg == ST_MAC) && (jc_reg < tok_reg);
    assign v2_next = v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tok_reg   <= '0;
            elem_reg  <= '0;
            jc_reg    <= '0;
            run_reg   <= '0;
            bank_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tok_reg   <= tok_next;
            elem_reg  <= elem_next;
            jc_reg    <= jc_next;
            run_reg   <= run_next;
            bank_reg  <= bank_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ke_reg    <= ke_next;
        gate_reg  <= gate_next;
        beta_reg  <= beta_next;
        send_reg  <= send_next;
        last_reg  <= last_next;
        first_reg <= first_next;
        j1_reg    <= jc_reg[IW-1:0];
        j2_reg    <= j1_reg;
        prod2_reg <= ke_reg * $signed(key_rdata);
        dot2_reg  <= first_reg ? 40'sd0 : dots_rdata;
    end

    assign full       = (state_reg != ST_IDLE);
    assign dots_bank  = bank_reg;
    assign dots_we    = v2_reg;
    assign dots_waddr = j2_reg;
    assign dots_wdata = dot2_reg + 40'(prod2_reg);
    assign dots_raddr = jc_reg[IW-1:0];

    assign cs_we    = fin_go;
    assign cs_waddr = tok_reg[IW-1:0];
    assign cs_wdata = sum_new;

    assign job_valid = fin_go;
    always_comb
    begin
        job.row  = gkg_pkg::JOB_ROW_W'(tok_reg);
        job.len  = gkg_pkg::JOB_LEN_W'(ch_len);
        job.cs   = sum_new;
        job.beta = beta_reg;
        job.bank = bank_reg;
    end

endmodule

>>> hw/rtl/gkg_back.sv
// back end: walks one row job column by column and queues the result words
module gkg_back #(
    parameter int MAX_CHUNK = 64,
    localparam int CW = $clog2(MAX_CHUNK + 1),
    localparam int IW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  gkg_pkg::job_t       job,
    output logic                back_idle,
    output logic                rd_bank,
    output logic [IW-1:0]       rd_addr,
    input  logic signed [39:0]  dots_rdata,
    input  logic signed [31:0]  cs_rdata,
    output logic                empty,
    input  logic                pop,
    output gkg_pkg::out_word_t  result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_LAT  = 3'd2;
    localparam logic [2:0] ST_EXPW = 3'd3;
    localparam logic [2:0] ST_MQ   = 3'd4;
    localparam logic [2:0] ST_MB   = 3'd5;
    localparam logic [2:0] ST_SAT  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       col_reg, col_next;
    gkg_pkg::job_t       job_reg, job_next;
    logic signed [39:0]  dot_reg;
    logic signed [57:0]  p1_reg;
    logic signed [41:0]  q_reg;
    logic signed [57:0]  p2_reg;
    logic signed [31:0]  a_reg, a_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                wp_reg, rp_reg;
    gkg_pkg::out_word_t  fifo_reg [2];

    logic                exp_done;
    logic [16:0]         exp_e;
    logic signed [32:0]  diff;
    logic signed [57:0]  rnd;
    logic                is_last;
    logic                ff_push, ff_pop;
    gkg_pkg::out_word_t  word;

    assign diff    = 33'(job_reg.cs) - 33'(cs_rdata);
    assign rnd     = (p2_reg + 58'sd8192) >>> 14;
    assign is_last = (8'(col_reg) + 8'd1) == job_reg.len;
    assign ff_push = (state_reg == ST_OUT) && (cnt_reg != 2'd2);
    assign ff_pop  = pop && (cnt_reg != 2'd0);

    gkg_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_LAT),
        .d     (diff),
        .done  (exp_done),
        .e     (exp_e)
    );

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        job_next   = job_reg;
        a_next     = a_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job;
                    col_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (8'(col_reg) < 8'(job_reg.row))
                begin
                    state_next = ST_LAT;
                end
                else
                begin
                    a_next     = '0;
                    state_next = ST_OUT;
                end
            end
            ST_LAT:
            begin
                state_next = ST_EXPW;
            end
            ST_EXPW:
            begin
                if (exp_done)
                begin
                    state_next = ST_MQ;
                end
            end
            ST_MQ:
            begin
                state_next = ST_MB;
            end
            ST_MB:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                a_next     = gkg_pkg::sat32(64'(rnd));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (cnt_reg != 2'd2)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + CW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        word.row_index   = 6'(job_reg.row);
        word.col_index   = 6'(col_reg);
        word.a_value     = a_reg;
        word.gate_cumsum = job_reg.cs;
        word.row_last    = is_last;
        cnt_next = cnt_reg + 2'(ff_push) - 2'(ff_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            cnt_reg   <= '0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            if (ff_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (ff_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        a_reg   <= a_next;
        if (state_reg == ST_LAT)
        begin
            dot_reg <= dots_rdata;
        end
        p1_reg <= dot_reg * $signed({1'b0, exp_e});
        q_reg  <= 42'((p1_reg + 58'sd32768) >>> 16);
        p2_reg <= q_reg * job_reg.beta;
        if (ff_push)
        begin
            fifo_reg[wp_reg] <= word;
        end
    end

    assign back_idle = (state_reg == ST_IDLE);
    assign rd_bank   = job_reg.bank;
    assign rd_addr   = col_reg[IW-1:0];
    assign empty     = (cnt_reg == 2'd0);
    assign result    = fifo_reg[rp_reg];

`ifndef SYNTHESIS
    a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (state_reg == ST_IDLE))
        else $error("row job issued while back end busy");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_exp_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAT) |=> (state_reg == ST_EXPW) && $stable(col_reg))
        else $error("exp start not followed by wait");

    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ff_push && is_last) |=> (state_reg == ST_IDLE))
        else $error("row did not close after last column");
`endif

endmodule

>>> hw/rtl/gated_key_gram_chunk.sv
// gated key gram chunk block: configuration, shared memories, front and back ends
//
// input queue: drive item and push while full is low; one word is one key
// element of the current token, gate/beta/seq_end are used on the token's
// last element. results: while empty is low, result holds the oldest word;
// pop takes it. one token's last element yields chunk length result words,
// one per column, row_last on the final one.
// config: cfg_valid with cfg_index/cfg_data, always ready; write only idle.
// timing: a key element runs the dot product loop, which visits one earlier
// token per cycle through the key ram. for each earlier column a row waits
// for the exp unit and two multiplies; each remaining column only queues a
// zero word. the front end works on the next token while a row drains and
// holds that token's last element until the back end is idle.
// reset clears all counters, the running gate sum and both queues; lengths
// return to 64. if pop stays low, a two word result queue fills, the back
// end stops, and then the front end stops at the next last element.
module gated_key_gram_chunk #(
    parameter int MAX_CHUNK = 64,
    parameter int MAX_KEY   = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  gkg_pkg::in_word_t               item,
    output logic                            empty,
    input  logic                            pop,
    output gkg_pkg::out_word_t              result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gkg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gkg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW  = $clog2(MAX_CHUNK + 1);
    localparam int IW  = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int KCW = $clog2(MAX_KEY + 1);

    logic [6:0]         chunk_len_reg;
    logic [7:0]         key_len_reg;
    logic [CW-1:0]      ch_eff;
    logic [KCW-1:0]     kl_eff;

    logic               back_idle;
    logic               job_valid;
    gkg_pkg::job_t      job;
    logic               f_bank, f_we, b_bank;
    logic [IW-1:0]      f_waddr, f_raddr, b_raddr;
    logic signed [39:0] f_wdata;
    logic [39:0]        rd0, rd1;
    logic signed [39:0] f_rdata, b_rdata;
    logic               cs_we;
    logic [IW-1:0]      cs_waddr;
    logic signed [31:0] cs_wdata;
    logic [31:0]        cs_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_len_reg <= gkg_pkg::CHUNK_LEN_RST;
            key_len_reg   <= gkg_pkg::KEY_LEN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gkg_pkg::REG_CHUNK_LEN: chunk_len_reg <= cfg_data[6:0];
                gkg_pkg::REG_KEY_LEN:   key_len_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign ch_eff = ((chunk_len_reg == '0) || (32'(chunk_len_reg) > MAX_CHUNK))
                    ? CW'(MAX_CHUNK) : CW'(chunk_len_reg);
    assign kl_eff = ((key_len_reg == '0) || (32'(key_len_reg) > MAX_KEY))
                    ? KCW'(MAX_KEY) : KCW'(key_len_reg);

    gkg_front #(.MAX_CHUNK(MAX_CHUNK), .MAX_KEY(MAX_KEY)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .ch_len     (ch_eff),
        .key_len    (kl_eff),
        .back_idle  (back_idle),
        .job_valid  (job_valid),
        .job        (job),
        .dots_bank  (f_bank),
        .dots_we    (f_we),
        .dots_waddr (f_waddr),
        .dots_wdata (f_wdata),
        .dots_raddr (f_raddr),
        .dots_rdata (f_rdata),
        .cs_we      (cs_we),
        .cs_waddr   (cs_waddr),
        .cs_wdata   (cs_wdata)
    );

    gkg_ram #(.WIDTH(40), .DEPTH(MAX_CHUNK)) u_dots0 (
        .clk   (clk),
        .we    (f_we && !f_bank),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_bank ? b_raddr : f_raddr),
        .rdata (rd0)
    );

    gkg_ram #(.WIDTH(40), .DEPTH(MAX_CHUNK)) u_dots1 (
        .clk   (clk),
        .we    (f_we && f_bank),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_bank ? f_raddr : b_raddr),
        .rdata (rd1)
    );

    assign f_rdata = $signed(f_bank ? rd1 : rd0);
    assign b_rdata = $signed(b_bank ? rd1 : rd0);

    gkg_ram #(.WIDTH(32), .DEPTH(MAX_CHUNK)) u_cumsum (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .raddr (b_raddr),
        .rdata (cs_rdata)
    );

    gkg_back #(.MAX_CHUNK(MAX_CHUNK)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .back_idle  (back_idle),
        .rd_bank    (b_bank),
        .rd_addr    (b_raddr),
        .dots_rdata (b_rdata),
        .cs_rdata   ($signed(cs_rdata)),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule
